/* hdl/software_timer_bank_unit_assert.svh */
// Assertion macros shared by the software timer bank RTL
`ifndef SOFTWARE_TIMER_BANK_UNIT_ASSERT_SVH
`define SOFTWARE_TIMER_BANK_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define STB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define STB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/stb_pkg.sv */
// Types and codes shared by the software timer bank modules
`timescale 1ns / 1ps

package stb_pkg;

  // Operation codes; the two remaining codes behave like a query
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_SCAN  = 3'd1,
    OP_START = 3'd2,
    OP_STOP  = 3'd3,
    OP_QUERY = 3'd4,
    OP_LOAD  = 3'd5
  } op_t;

  // Per-timer state
  typedef enum logic [1:0] {
    ST_HALTED  = 2'd0,
    ST_STARTED = 2'd1,
    ST_RUNNING = 2'd2,
    ST_ELAPSED = 2'd3
  } timer_state_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_REPORT
  } ctrl_state_t;

  // Input transaction
  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  timer_index;
    logic [15:0] duration_value;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]  timer_status;
    logic [15:0] elapsed_ticks;
    logic        not_running;
    logic        index_invalid;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_step;
    logic report;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_scan;
    logic out_free;
  } status_t;

endpackage

/* hdl/stb_datapath.sv */
// Timer bank datapath: timer storage, time base, scan update and result register
`timescale 1ns / 1ps

module stb_datapath #(
  parameter int NUM_TIMERS = 8,
  parameter int IDX_W      = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  stb_pkg::in_t      in_data,
  input  stb_pkg::cmd_t     cmd,
  input  logic [IDX_W-1:0]  scan_idx,
  output stb_pkg::status_t  status,
  output logic              out_valid,
  input  logic              out_stall,
  output stb_pkg::out_t     out_data
);
  import stb_pkg::*;

  // Timer storage
  logic [15:0]  time_base;
  timer_state_t tstate     [NUM_TIMERS];
  logic [15:0]  start_time [NUM_TIMERS];
  logic [15:0]  duration   [NUM_TIMERS];

  // Captured transaction
  in_t item;

  logic             idx_ok;
  logic [IDX_W-1:0] idx_trunc;
  logic [IDX_W-1:0] rd_addr;
  timer_state_t     rd_state;
  logic [15:0]      rd_start;
  logic [15:0]      rd_dur;
  logic [15:0]      diff;

  // Index check and the single shared read port
  assign idx_ok    = ({1'b0, item.timer_index} < 5'(NUM_TIMERS));
  assign idx_trunc = item.timer_index[IDX_W-1:0];
  assign rd_addr   = cmd.scan_step ? scan_idx : idx_trunc;
  assign rd_state  = tstate[rd_addr];
  assign rd_start  = start_time[rd_addr];
  assign rd_dur    = duration[rd_addr];
  assign diff      = time_base - rd_start;

  assign status.is_scan  = (in_data.operation == OP_SCAN);
  assign status.out_free = !out_valid || !out_stall;

  // Capture of the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
  end

  // Timer state updates: executed operations and scan steps
  always_ff @(posedge clk) begin
    if (rst) begin
      time_base <= '0;
      for (int k = 0; k < NUM_TIMERS; k++) begin
        tstate[k]     <= ST_HALTED;
        start_time[k] <= '0;
        duration[k]   <= '0;
      end
    end else if (cmd.exec) begin
      case (item.operation)
        OP_TICK: begin
          time_base <= time_base + 16'd1;
        end
        OP_START: begin
          if (idx_ok) tstate[idx_trunc] <= ST_STARTED;
        end
        OP_STOP: begin
          if (idx_ok) tstate[idx_trunc] <= ST_HALTED;
        end
        OP_LOAD: begin
          if (idx_ok) duration[idx_trunc] <= item.duration_value;
        end
        default: begin
        end
      endcase
    end else if (cmd.scan_step) begin
      // a running timer elapses first; a started one begins running now
      if (rd_state == ST_RUNNING && diff >= rd_dur) begin
        tstate[rd_addr] <= ST_ELAPSED;
      end else if (rd_state == ST_STARTED) begin
        tstate[rd_addr]     <= ST_RUNNING;
        start_time[rd_addr] <= time_base;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.report) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      if (idx_ok) begin
        out_data.timer_status  <= rd_state;
        out_data.elapsed_ticks <= diff;
        out_data.not_running   <= (rd_state == ST_HALTED);
        out_data.index_invalid <= 1'b0;
      end else begin
        out_data.timer_status  <= '0;
        out_data.elapsed_ticks <= '0;
        out_data.not_running   <= 1'b0;
        out_data.index_invalid <= 1'b1;
      end
    end
  end

endmodule

/* hdl/stb_controller.sv */
// Timer bank controller: transaction sequencing and scan counter
`timescale 1ns / 1ps
`include "software_timer_bank_unit_assert.svh"

module stb_controller #(
  parameter int NUM_TIMERS = 8,
  parameter int IDX_W      = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  stb_pkg::status_t  status,
  output stb_pkg::cmd_t     cmd,
  output logic [IDX_W-1:0]  scan_idx
);
  import stb_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  ctrl_state_t      state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;

  assign scan_idx = cnt;

  // State and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_stall   = 1'b1;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        // no transaction is taken while reset is held
        in_stall = rst;
        if (in_valid && !rst) begin
          cmd.capture = 1'b1;
          cnt_next    = '0;
          state_next  = status.is_scan ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_REPORT;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (cnt == LAST_IDX) begin
          state_next = S_REPORT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_REPORT: begin
        if (status.out_free) begin
          cmd.report = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `STB_ASSERT_NEXT(a_accept_leaves_idle, state == S_IDLE && in_valid, state != S_IDLE, "accepted transaction did not start")
  `STB_ASSERT_NEXT(a_last_step_reports, state == S_SCAN && cnt == LAST_IDX, state == S_REPORT, "scan did not end after last timer")
  `STB_ASSERT_IMP(a_report_needs_room, cmd.report, status.out_free, "result written while output register held")
  `STB_ASSERT_NEXT(a_scan_counts_up, state == S_SCAN && cnt != LAST_IDX, state == S_SCAN && cnt == $past(cnt) + 1'b1, "scan counter skipped")

endmodule

/* hdl/software_timer_bank_unit.sv */
// Software timer bank: top level joining controller and datapath
// Tick, start, stop, query and load: accepted in idle, executed, then reported into the
// result register; a new transaction is taken only once the controller is back in idle.
// Scan: one timer per cycle through the shared read/update port, then a report; no new
// transaction is taken until the scan has been reported.
// A stalled result holds the controller in its report state until taken.
// Synchronous reset: time base and start times zero, durations zero, all timers halted.
`timescale 1ns / 1ps

module software_timer_bank_unit #(
  parameter int NUM_TIMERS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  stb_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output stb_pkg::out_t out_data
);
  import stb_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  cmd_t             cmd;
  status_t          status;
  logic [IDX_W-1:0] scan_idx;

  stb_controller #(
    .NUM_TIMERS (NUM_TIMERS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd),
    .scan_idx (scan_idx)
  );

  stb_datapath #(
    .NUM_TIMERS (NUM_TIMERS),
    .IDX_W      (IDX_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .scan_idx  (scan_idx),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* test/software_timer_bank_unit_check.sv */
// Watches both channels of the software timer bank, predicts each report and compares it
`timescale 1ns / 1ps

module software_timer_bank_unit_check #(
  parameter int NUM_TIMERS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_stall,
  input  stb_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  stb_pkg::out_t out_data,
  output int            fail_count,
  output int            expected_left,
  output int            reports_checked
);
  import stb_pkg::*;

  // keep the log short when something goes badly wrong
  localparam int MAX_PRINTED = 100;

  // Shadow copy of the timer bank
  logic [15:0]  time_base_q;
  timer_state_t tmr_state [NUM_TIMERS];
  logic [15:0]  tmr_start [NUM_TIMERS];
  logic [15:0]  tmr_limit [NUM_TIMERS];

  // Reports owed by the block, oldest first
  out_t pending_reports[$];

  initial begin
    fail_count      = 0;
    expected_left   = 0;
    reports_checked = 0;
  end

  task automatic flag_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_PRINTED) begin
      $display("MISMATCH @%0t: %s", $time, what);
    end
  endtask

  // Ticks since a timer's start, wrapping at 16 bits
  function automatic logic [15:0] ticks_since(input int k);
    ticks_since = time_base_q - tmr_start[k];
  endfunction

  // Apply one transaction to the shadow bank and return the report it produces
  function automatic out_t predict_timer_report(input in_t t);
    out_t r;
    logic ok;
    int   i;
    int   k;
    ok = (t.timer_index < NUM_TIMERS);
    i  = t.timer_index;
    case (t.operation)
      OP_TICK: time_base_q = time_base_q + 16'd1;
      OP_SCAN: begin
        // elapse check first, then promote started timers
        for (k = 0; k < NUM_TIMERS; k++) begin
          if (tmr_state[k] == ST_RUNNING && ticks_since(k) >= tmr_limit[k]) begin
            tmr_state[k] = ST_ELAPSED;
          end
          if (tmr_state[k] == ST_STARTED) begin
            tmr_start[k] = time_base_q;
            tmr_state[k] = ST_RUNNING;
          end
        end
      end
      OP_START: if (ok) tmr_state[i] = ST_STARTED;
      OP_STOP:  if (ok) tmr_state[i] = ST_HALTED;
      OP_LOAD:  if (ok) tmr_limit[i] = t.duration_value;
      default: ;
    endcase
    // every operation reports the addressed timer
    r = '0;
    if (ok) begin
      r.timer_status  = tmr_state[i];
      r.elapsed_ticks = ticks_since(i);
      r.not_running   = (tmr_state[i] == ST_HALTED);
    end else begin
      r.index_invalid = 1'b1;
    end
    return r;
  endfunction

  // Sample both handshakes at the clock edge
  always @(posedge clk) begin : watch
    out_t oldest;
    int   k;
    if (rst) begin
      time_base_q = '0;
      for (k = 0; k < NUM_TIMERS; k++) begin
        tmr_state[k] = ST_HALTED;
        tmr_start[k] = '0;
        tmr_limit[k] = '0;
      end
      pending_reports.delete();
    end else begin
      if (in_valid && !in_stall) begin
        pending_reports.push_back(predict_timer_report(in_data));
      end
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          flag_mismatch("report with no transaction waiting for it");
        end else begin
          oldest = pending_reports.pop_front();
          reports_checked++;
          if (out_data.timer_status !== oldest.timer_status) begin
            flag_mismatch($sformatf("timer_status got %0d want %0d",
                                    out_data.timer_status, oldest.timer_status));
          end
          if (out_data.elapsed_ticks !== oldest.elapsed_ticks) begin
            flag_mismatch($sformatf("elapsed_ticks got %0d want %0d",
                                    out_data.elapsed_ticks, oldest.elapsed_ticks));
          end
          if (out_data.not_running !== oldest.not_running) begin
            flag_mismatch($sformatf("not_running got %0b want %0b",
                                    out_data.not_running, oldest.not_running));
          end
          if (out_data.index_invalid !== oldest.index_invalid) begin
            flag_mismatch($sformatf("index_invalid got %0b want %0b",
                                    out_data.index_invalid, oldest.index_invalid));
          end
        end
      end
    end
    expected_left <= pending_reports.size();
  end

endmodule

/* test/software_timer_bank_unit_tb.sv */
// Stimulus and verdict for the software timer bank, with the report check beside the block
`timescale 1ns / 1ps

module software_timer_bank_unit_tb;
  import stb_pkg::*;

  localparam int NUM_TIMERS = 8;
  // codes past the last operation; the block treats them as a query
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int FIRST_RANDOM_END = 650;
  localparam int SECOND_RANDOM_LEN = 700;
  localparam int CYCLE_LIMIT = 300_000;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int fail_count;
  int expected_left;
  int reports_checked;

  // stretches with no idling on either side
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;

  int items_sent = 0;
  int scans_sent = 0;
  int ticks_sent = 0;
  int cycles = 0;

  software_timer_bank_unit #(.NUM_TIMERS(NUM_TIMERS)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  software_timer_bank_unit_check #(.NUM_TIMERS(NUM_TIMERS)) report_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .expected_left  (expected_left),
    .reports_checked(reports_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d reports still owed", cycles, expected_left);
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stall after each accepted report
  initial begin : result_side
    int gap;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        gap = out_calm ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // One transaction: optional idle gap, then hold until accepted
  task automatic send_op(input logic [2:0] op, input logic [3:0] idx,
                         input logic [15:0] dur);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{operation: op, timer_index: idx, duration_value: dur};
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (op == OP_SCAN) scans_sent++;
    if (op == OP_TICK) ticks_sent++;
  endtask

  // Mostly short durations so timers actually elapse, with extremes mixed in
  function automatic logic [15:0] pick_duration();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 16'($urandom_range(0, 24));
    if (pick < 80) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  task automatic send_random_item();
    logic [2:0]  op;
    logic [3:0]  idx;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      op = OP_TICK;
    else if (pick < 48) op = OP_SCAN;
    else if (pick < 60) op = OP_START;
    else if (pick < 68) op = OP_STOP;
    else if (pick < 80) op = OP_QUERY;
    else if (pick < 94) op = OP_LOAD;
    else if (pick < 97) op = OP_SPARE_LO;
    else                op = OP_SPARE_HI;
    if ($urandom_range(0, 9) == 0) idx = 4'($urandom_range(NUM_TIMERS, 15));
    else                           idx = 4'($urandom_range(0, NUM_TIMERS - 1));
    send_op(op, idx, pick_duration());
  endtask

  // Load, start, scan, tick around the duration, scan, query and sometimes stop one timer
  task automatic run_timer_lifecycle();
    logic [3:0]  idx;
    logic [15:0] dur;
    int          n;
    idx = 4'($urandom_range(0, NUM_TIMERS - 1));
    dur = 16'($urandom_range(0, 12));
    send_op(OP_LOAD, idx, dur);
    send_op(OP_START, idx, 16'($urandom));
    send_op(OP_SCAN, idx, 16'($urandom));
    n = int'(dur) + $urandom_range(0, 3) - 1;
    if (n < 0) n = 0;
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) send_random_item();
      send_op(OP_TICK, idx, 16'($urandom));
    end
    send_op(OP_SCAN, idx, 16'($urandom));
    send_op(OP_QUERY, idx, 16'($urandom));
    if ($urandom_range(0, 2) == 0) send_op(OP_STOP, idx, 16'($urandom));
  endtask

  task automatic run_random_until(input int stop_at);
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) begin
        in_calm  = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 9) < 6) run_timer_lifecycle();
      else                          send_random_item();
    end
  endtask

  // Main sequence
  initial begin : stimulus
    int k;
    int second_end;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset state, invalid indices, zero and full durations, spare codes
    send_op(OP_QUERY, 4'd0, 16'h0000);
    send_op(OP_QUERY, 4'd15, 16'hFFFF);
    send_op(OP_LOAD, 4'd0, 16'h0000);
    send_op(OP_LOAD, 4'd7, 16'hFFFF);
    send_op(OP_LOAD, 4'd8, 16'h1234);
    send_op(OP_START, 4'd0, 16'h0000);
    send_op(OP_START, 4'd7, 16'h0000);
    send_op(OP_START, 4'd9, 16'h0000);
    send_op(OP_SCAN, 4'd0, 16'h0000);
    send_op(OP_SCAN, 4'd0, 16'h0000);
    send_op(OP_TICK, 4'd7, 16'h0000);
    send_op(OP_QUERY, 4'd7, 16'h0000);
    send_op(OP_STOP, 4'd7, 16'h0000);
    send_op(OP_STOP, 4'd12, 16'h0000);
    send_op(OP_SPARE_LO, 4'd3, 16'h0000);
    send_op(OP_SPARE_HI, 4'd15, 16'h0000);
    send_op(OP_LOAD, 4'd3, 16'hAAAA);
    send_op(OP_LOAD, 4'd3, 16'h5555);
    send_op(OP_START, 4'd3, 16'h0000);
    send_op(OP_SCAN, 4'd3, 16'h0000);
    send_op(OP_TICK, 4'd3, 16'h0000);
    send_op(OP_STOP, 4'd3, 16'h0000);
    send_op(OP_QUERY, 4'd3, 16'hFFFF);

    run_random_until(FIRST_RANDOM_END);

    // Arm every timer with a wide duration so all of them run at once
    for (k = 0; k < NUM_TIMERS; k++) begin
      send_op(OP_LOAD, 4'(k), ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'hFFFF);
      send_op(OP_START, 4'(k), 16'($urandom));
    end
    send_op(OP_SCAN, 4'd0, 16'h0000);

    // Random traffic again over the armed bank
    second_end = items_sent + SECOND_RANDOM_LEN;
    run_random_until(second_end);

    // Drain
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
    repeat (20) @(posedge clk);

    $display("Sent %0d transactions: %0d ticks, %0d scans, invalid indices and spare codes.",
             items_sent, ticks_sent, scans_sent);
    $display("Compared %0d reports field by field, %0d mismatches.",
             reports_checked, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/stb_pkg.sv
hdl/stb_datapath.sv
hdl/stb_controller.sv
hdl/software_timer_bank_unit.sv
test/software_timer_bank_unit_check.sv
test/software_timer_bank_unit_tb.sv
